// ===== hw/rtl/bir_pkg.sv =====
// Shared types, constants and helpers of the bilinear image resizer.
// Used by bir_div and bilinear_image_resize_top; no dependencies.
package bir_pkg;

	localparam int MAX_SOURCE_WIDTH  = 512;
	localparam int MAX_SOURCE_HEIGHT = 512;
	localparam int MAX_TARGET_SIZE   = 1024;

	localparam int POS_W  = 10;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 3;
	localparam int STEP_W = 24;
	localparam int FRAC_W = 16;
	localparam int WGT_W  = 8;

	localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd512;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_CLAMP,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_ACC,
		ST_FIN
	} state_t;

	function automatic logic [31:0] eff_size(input logic [31:0] v, input logic [31:0] maxv);
		logic [31:0] r;
		if (v == 32'd0)
			r = 32'd1;
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== hw/rtl/bir_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bir_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/bir_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to a Q8.16 step.
// Depends on bir_pkg.
module bir_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic                       busy,
	output logic [bir_pkg::STEP_W-1:0] step
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [31:0]      quot_ext;

	assign rem_sh   = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits     = rem_sh >= {1'b0, den_q};
	assign busy     = cnt_q != '0;
	assign quot_ext = 32'(quot_q);
	assign step     = (quot_ext > 32'hFFFFFF) ? '1 : quot_ext[bir_pkg::STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

endmodule

// ===== hw/rtl/bilinear_image_resize_top.sv =====
// Bilinear image resizer with pixel-centre mapping and a single-port image store.
// Depends on bir_pkg, bir_ram and bir_div.
//
// Usage:
//   Input channel (in_valid/in_ready): mode 0 loads one source pixel at pos_x,
//   pos_y; loads outside the source size are dropped. Mode 1 requests one
//   destination pixel; each request yields exactly one result on the output
//   channel (out_valid/out_ready).
//   A request passes two steps of coordinate mapping, four reads of the single
//   store port, one accumulate step and one hand-over step before it reaches
//   the output register. The input is taken again only when the block is back
//   in idle, so no new input is taken while a request is in progress. An
//   out-of-range request goes straight to the hand-over step and returns
//   out_error with zero channels.
//   The output register holds a result while the receiver stalls; the block
//   keeps taking loads, and a further request waits in its last step until the
//   output register frees.
//   Configuration: cfg_we writes register cfg_index with cfg_data at once.
//   After reset and after every register write the two scale steps are
//   recomputed by serial dividers, one bit a cycle; in_ready stays low from
//   the divider start until both dividers are idle.
//   Store contents are undefined after reset; request only pixels loaded.
module bilinear_image_resize_top #(
	parameter int MAX_SOURCE_WIDTH  = bir_pkg::MAX_SOURCE_WIDTH,
	parameter int MAX_SOURCE_HEIGHT = bir_pkg::MAX_SOURCE_HEIGHT,
	parameter int MAX_TARGET_SIZE   = bir_pkg::MAX_TARGET_SIZE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bir_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bir_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [bir_pkg::POS_W-1:0]   pos_x,
	input  logic [bir_pkg::POS_W-1:0]   pos_y,
	input  logic [bir_pkg::CH_W-1:0]    in_blue,
	input  logic [bir_pkg::CH_W-1:0]    in_green,
	input  logic [bir_pkg::CH_W-1:0]    in_red,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bir_pkg::CH_W-1:0]    out_blue,
	output logic [bir_pkg::CH_W-1:0]    out_green,
	output logic [bir_pkg::CH_W-1:0]    out_red,
	output logic                        out_error
);

	localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW_W  = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int SH_W  = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int TS_W  = $clog2(MAX_TARGET_SIZE + 1);
	localparam int XW    = $clog2(MAX_SOURCE_WIDTH);
	localparam int YW    = $clog2(MAX_SOURCE_HEIGHT);
	localparam int P_W   = bir_pkg::POS_W + 1 + bir_pkg::STEP_W + 1;
	localparam int B_W   = P_W - (bir_pkg::FRAC_W + 1);
	localparam int WP_W  = 2 * (bir_pkg::WGT_W + 1);
	localparam int ACC_W = bir_pkg::CH_W + WP_W;
	localparam int CW    = bir_pkg::CH_W;
	localparam int SAT_LSB = bir_pkg::FRAC_W + CW;

	// configuration
	logic [bir_pkg::CFG_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic                      step_go_q;
	logic [SW_W-1:0]           sw;
	logic [SH_W-1:0]           sh;
	logic [TS_W-1:0]           tw, th;
	logic                      div_h_busy, div_v_busy;
	logic [bir_pkg::STEP_W-1:0] step_h, step_v;

	assign sw = SW_W'(bir_pkg::eff_size(32'(src_w_q), 32'(MAX_SOURCE_WIDTH)));
	assign sh = SH_W'(bir_pkg::eff_size(32'(src_h_q), 32'(MAX_SOURCE_HEIGHT)));
	assign tw = TS_W'(bir_pkg::eff_size(32'(tgt_w_q), 32'(MAX_TARGET_SIZE)));
	assign th = TS_W'(bir_pkg::eff_size(32'(tgt_h_q), 32'(MAX_TARGET_SIZE)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= bir_pkg::SIZE_RESET;
			src_h_q   <= bir_pkg::SIZE_RESET;
			tgt_w_q   <= bir_pkg::SIZE_RESET;
			tgt_h_q   <= bir_pkg::SIZE_RESET;
			step_go_q <= 1'b1;
		end else begin
			step_go_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					bir_pkg::REG_SOURCE_WIDTH:  src_w_q <= {1'b0, cfg_data[9:0]};
					bir_pkg::REG_SOURCE_HEIGHT: src_h_q <= {1'b0, cfg_data[9:0]};
					bir_pkg::REG_TARGET_WIDTH:  tgt_w_q <= cfg_data;
					bir_pkg::REG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	bir_div #(.NUM_W(SW_W + bir_pkg::FRAC_W), .DEN_W(TS_W)) u_div_h (
		.clk(clk), .arst_n(arst_n), .start(step_go_q),
		.num({sw, bir_pkg::FRAC_W'(0)}), .den(tw),
		.busy(div_h_busy), .step(step_h)
	);

	bir_div #(.NUM_W(SH_W + bir_pkg::FRAC_W), .DEN_W(TS_W)) u_div_v (
		.clk(clk), .arst_n(arst_n), .start(step_go_q),
		.num({sh, bir_pkg::FRAC_W'(0)}), .den(th),
		.busy(div_v_busy), .step(step_v)
	);

	// request state and datapath registers
	bir_pkg::state_t state_q, state_d;
	logic [bir_pkg::POS_W-1:0] px_q, py_q;
	logic                      err_q;
	logic signed [P_W-1:0]     p_x_s1, p_y_s1;
	logic [AW-1:0]             row0_s2, row1_s2;
	logic [XW-1:0]             x0_s2, x1_s2;
	logic [WP_W-1:0]           w00_s2, w01_s2, w10_s2, w11_s2;
	logic [ACC_W-1:0]          acc_b_q, acc_g_q, acc_r_q;
	logic                      out_valid_q, out_error_q;
	logic [CW-1:0]             out_b_q, out_g_q, out_r_q;

	// control outputs
	logic            accept, req_err, out_load, acc_en, ram_we;
	logic [AW-1:0]   ram_addr, load_addr;
	logic [WP_W-1:0] w_sel;
	logic [bir_pkg::PIX_W-1:0] rdata;

	assign accept  = in_valid && in_ready;
	assign req_err = (32'(pos_x) >= 32'(tw)) || (32'(pos_y) >= 32'(th));
	assign load_addr = AW'(AW'(pos_y) * AW'(MAX_SOURCE_WIDTH)) + AW'(pos_x);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bir_pkg::ST_IDLE:
				if (accept && mode == bir_pkg::MODE_REQUEST)
					state_d = req_err ? bir_pkg::ST_FIN : bir_pkg::ST_MAP;
			bir_pkg::ST_MAP:   state_d = bir_pkg::ST_CLAMP;
			bir_pkg::ST_CLAMP: state_d = bir_pkg::ST_RD0;
			bir_pkg::ST_RD0:   state_d = bir_pkg::ST_RD1;
			bir_pkg::ST_RD1:   state_d = bir_pkg::ST_RD2;
			bir_pkg::ST_RD2:   state_d = bir_pkg::ST_RD3;
			bir_pkg::ST_RD3:   state_d = bir_pkg::ST_ACC;
			bir_pkg::ST_ACC:   state_d = bir_pkg::ST_FIN;
			bir_pkg::ST_FIN:
				if (!out_valid_q || out_ready)
					state_d = bir_pkg::ST_IDLE;
			default: state_d = bir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		acc_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = load_addr;
		w_sel    = w00_s2;
		unique case (state_q)
			bir_pkg::ST_IDLE: begin
				in_ready = !step_go_q && !div_h_busy && !div_v_busy;
				ram_we   = accept && mode == bir_pkg::MODE_LOAD
					&& (32'(pos_x) < 32'(sw)) && (32'(pos_y) < 32'(sh));
			end
			bir_pkg::ST_RD0: ram_addr = row0_s2 + AW'(x0_s2);
			bir_pkg::ST_RD1: begin
				ram_addr = row0_s2 + AW'(x1_s2);
				acc_en   = 1'b1;
				w_sel    = w00_s2;
			end
			bir_pkg::ST_RD2: begin
				ram_addr = row1_s2 + AW'(x0_s2);
				acc_en   = 1'b1;
				w_sel    = w01_s2;
			end
			bir_pkg::ST_RD3: begin
				ram_addr = row1_s2 + AW'(x1_s2);
				acc_en   = 1'b1;
				w_sel    = w10_s2;
			end
			bir_pkg::ST_ACC: begin
				acc_en = 1'b1;
				w_sel  = w11_s2;
			end
			bir_pkg::ST_FIN: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	bir_ram #(.WIDTH(bir_pkg::PIX_W), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata({in_red, in_green, in_blue}), .rdata(rdata)
	);

	// coordinate mapping helpers for the clamp stage
	localparam int WGT_W_L = bir_pkg::WGT_W;
	logic signed [B_W-1:0] bx, by, bx1, by1;
	logic [WGT_W_L-1:0]    wx, wy;
	logic [WGT_W_L:0]      ix, iy, wxe, wye;

	assign bx  = B_W'(p_x_s1 >>> (bir_pkg::FRAC_W + 1));
	assign by  = B_W'(p_y_s1 >>> (bir_pkg::FRAC_W + 1));
	assign bx1 = bx + B_W'(1);
	assign by1 = by + B_W'(1);
	assign wx  = p_x_s1[bir_pkg::FRAC_W:bir_pkg::FRAC_W - WGT_W_L + 1];
	assign wy  = p_y_s1[bir_pkg::FRAC_W:bir_pkg::FRAC_W - WGT_W_L + 1];
	assign wxe = {1'b0, wx};
	assign wye = {1'b0, wy};
	assign ix  = (WGT_W_L + 1)'(1 << WGT_W_L) - wxe;
	assign iy  = (WGT_W_L + 1)'(1 << WGT_W_L) - wye;

	function automatic logic [31:0] clamp_idx(input logic signed [B_W-1:0] b,
			input logic [31:0] size);
		logic [31:0] r;
		if (b < 0)
			r = 32'd0;
		else if ($signed(33'(b)) > $signed({1'b0, size - 32'd1}))
			r = size - 32'd1;
		else
			r = 32'(b);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bir_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode == bir_pkg::MODE_REQUEST) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			err_q   <= req_err;
			acc_b_q <= '0;
			acc_g_q <= '0;
			acc_r_q <= '0;
		end
		if (state_q == bir_pkg::ST_MAP) begin
			p_x_s1 <= $signed(P_W'(P_W'({px_q, 1'b1}) * P_W'(step_h)))
				- $signed(P_W'(1 << bir_pkg::FRAC_W));
			p_y_s1 <= $signed(P_W'(P_W'({py_q, 1'b1}) * P_W'(step_v)))
				- $signed(P_W'(1 << bir_pkg::FRAC_W));
		end
		if (state_q == bir_pkg::ST_CLAMP) begin
			x0_s2   <= XW'(clamp_idx(bx, 32'(sw)));
			x1_s2   <= XW'(clamp_idx(bx1, 32'(sw)));
			row0_s2 <= AW'(AW'(YW'(clamp_idx(by, 32'(sh)))) * AW'(MAX_SOURCE_WIDTH));
			row1_s2 <= AW'(AW'(YW'(clamp_idx(by1, 32'(sh)))) * AW'(MAX_SOURCE_WIDTH));
			w00_s2  <= ix * iy;
			w01_s2  <= wxe * iy;
			w10_s2  <= ix * wye;
			w11_s2  <= wxe * wye;
		end
		if (acc_en) begin
			acc_b_q <= acc_b_q + ACC_W'(rdata[CW-1:0] * w_sel);
			acc_g_q <= acc_g_q + ACC_W'(rdata[2*CW-1:CW] * w_sel);
			acc_r_q <= acc_r_q + ACC_W'(rdata[3*CW-1:2*CW] * w_sel);
		end
		if (out_load) begin
			out_error_q <= err_q;
			out_b_q <= (|acc_b_q[ACC_W-1:SAT_LSB]) ? '1
				: acc_b_q[SAT_LSB-1:bir_pkg::FRAC_W];
			out_g_q <= (|acc_g_q[ACC_W-1:SAT_LSB]) ? '1
				: acc_g_q[SAT_LSB-1:bir_pkg::FRAC_W];
			out_r_q <= (|acc_r_q[ACC_W-1:SAT_LSB]) ? '1
				: acc_r_q[SAT_LSB-1:bir_pkg::FRAC_W];
		end
	end

	assign out_valid = out_valid_q;
	assign out_error = out_error_q;
	assign out_blue  = out_b_q;
	assign out_green = out_g_q;
	assign out_red   = out_r_q;

endmodule
